### rtl/csse_pkg.sv
// shared types, constants and alphabet functions for the crypt salt string encoder
// no dependencies; the lane, merge, serializer and top-level files import this package

package csse_pkg;

  // result string geometry
  localparam int STR_LEN   = 29;
  localparam int IDX_W     = $clog2(STR_LEN);
  localparam int NUM_LANES = 6;

  typedef logic [7:0]       char_t;
  typedef logic [IDX_W-1:0] idx_t;

  // opcode of a request, also the form of the string
  typedef enum logic [1:0] {
    FORM_TDES = 2'd0,
    FORM_EDES = 2'd1,
    FORM_MD5  = 2'd2,
    FORM_BF   = 2'd3
  } form_t;

  // group order and alphabet used by a lane
  typedef enum logic {
    LANE_LE_STD = 1'b0,
    LANE_BE_BF  = 1'b1
  } lane_mode_t;

  typedef logic [2:0][7:0] tri_t;
  typedef char_t [3:0]     quad_t;

  // decoded request handed to the merge stage
  typedef struct packed {
    logic       failed;
    form_t      form;
    logic       md5_long;
    logic [4:0] cost;
  } dec_t;

  // assembled string handed to the serializer
  typedef struct packed {
    char_t [STR_LEN-1:0] chars;
    idx_t                last_idx;
    logic                failed;
  } str_t;

  // literal characters
  localparam char_t CH_NUL    = 8'h00;
  localparam char_t CH_DOLLAR = 8'h24;
  localparam char_t CH_UNDER  = 8'h5f;
  localparam char_t CH_ZERO   = 8'h30;
  localparam char_t CH_ONE    = 8'h31;
  localparam char_t CH_TWO    = 8'h32;
  localparam char_t CH_LOW_A  = 8'h61;

  // limits of the request checks
  localparam logic [7:0]  CAP_RESET     = 8'd64;
  localparam logic [31:0] TDES_ROUNDS   = 32'd25;
  localparam logic [31:0] MD5_ROUNDS    = 32'd1000;
  localparam logic [23:0] EDES_DEFAULT  = 24'd725;
  localparam logic [4:0]  BF_DEFAULT    = 5'd5;
  localparam logic [4:0]  BYTES_MAX     = 5'd16;

  // last index of each form
  localparam idx_t LAST_TDES    = idx_t'(1);
  localparam idx_t LAST_EDES    = idx_t'(8);
  localparam idx_t LAST_MD5     = idx_t'(6);
  localparam idx_t LAST_MD5_LNG = idx_t'(10);
  localparam idx_t LAST_BF      = idx_t'(STR_LEN-1);

  // "./0-9A-Za-z"
  function automatic char_t alpha_std(input logic [5:0] v);
    char_t c;
    c = {2'b00, v};
    if (v < 6'd12) begin
      alpha_std = c + 8'd46;
    end else if (v < 6'd38) begin
      alpha_std = c + 8'd53;
    end else begin
      alpha_std = c + 8'd59;
    end
  endfunction

  // "./A-Za-z0-9"
  function automatic char_t alpha_bf(input logic [5:0] v);
    char_t c;
    c = {2'b00, v};
    if (v < 6'd2) begin
      alpha_bf = c + 8'd46;
    end else if (v < 6'd28) begin
      alpha_bf = c + 8'd63;
    end else if (v < 6'd54) begin
      alpha_bf = c + 8'd69;
    end else begin
      alpha_bf = c - 8'd6;
    end
  endfunction

endpackage

### rtl/csse_if.sv
// channel interfaces of the crypt salt string encoder: request, result, configuration
// no dependencies; payload widths match the fields of csse_pkg

interface csse_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] round_count;
  logic [63:0] salt_lo;
  logic [63:0] salt_hi;
  logic [4:0]  byte_count;

  modport source (output valid, opcode, round_count, salt_lo, salt_hi, byte_count,
                  input ready);
  modport sink (input valid, opcode, round_count, salt_lo, salt_hi, byte_count,
                output ready);
endinterface

interface csse_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;
  logic       failed;

  modport source (output valid, text_char, last_char, failed, input ready);
  modport sink (input valid, text_char, last_char, failed, output ready);
endinterface

interface csse_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/csse_lane.sv
// one encoding lane: three bytes into four 6-bit groups, each mapped to a character
// depends on csse_pkg for the alphabets and lane types

module csse_lane (
  input  csse_pkg::lane_mode_t mode,
  input  csse_pkg::tri_t       bytes,
  output csse_pkg::quad_t      chars
);
  import csse_pkg::*;

  logic [23:0] word_le;
  logic [23:0] word_be;

  assign word_le = {bytes[2], bytes[1], bytes[0]};
  assign word_be = {bytes[0], bytes[1], bytes[2]};

  // little-endian groups lowest first, or big-endian groups highest first
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      unique case (mode)
        LANE_LE_STD: chars[k] = alpha_std(word_le[6*k +: 6]);
        LANE_BE_BF:  chars[k] = alpha_bf(word_be[18-6*k +: 6]);
        default:     chars[k] = CH_NUL;
      endcase
    end
  end

endmodule

### rtl/csse_merge.sv
// merge stage: places prefix literals, cost digits and lane characters into one string
// depends on csse_pkg for the decoded request and string types

module csse_merge (
  input  csse_pkg::dec_t                           dec,
  input  csse_pkg::quad_t [csse_pkg::NUM_LANES-1:0] lane_chars,
  output csse_pkg::str_t                           str
);
  import csse_pkg::*;

  logic [1:0] tens;
  logic [4:0] tens_val;
  logic [4:0] ones;

  // two decimal digits of the bcrypt cost, which stays below 32
  always_comb begin
    if (dec.cost >= 5'd30) begin
      tens = 2'd3;
    end else if (dec.cost >= 5'd20) begin
      tens = 2'd2;
    end else if (dec.cost >= 5'd10) begin
      tens = 2'd1;
    end else begin
      tens = 2'd0;
    end
    tens_val = {tens, 3'b000} + {2'b00, tens, 1'b0};
    ones     = dec.cost - tens_val;
  end

  // string layout per form
  always_comb begin
    str.chars    = '0;
    str.last_idx = '0;
    str.failed   = dec.failed;
    if (!dec.failed) begin
      unique case (dec.form)
        FORM_TDES: begin
          str.chars[0] = lane_chars[0][0];
          str.chars[1] = lane_chars[1][0];
          str.last_idx = LAST_TDES;
        end
        FORM_EDES: begin
          str.chars[0] = CH_UNDER;
          for (int k = 0; k < 4; k++) begin
            str.chars[1+k] = lane_chars[0][k];
            str.chars[5+k] = lane_chars[1][k];
          end
          str.last_idx = LAST_EDES;
        end
        FORM_MD5: begin
          str.chars[0] = CH_DOLLAR;
          str.chars[1] = CH_ONE;
          str.chars[2] = CH_DOLLAR;
          for (int k = 0; k < 4; k++) begin
            str.chars[3+k] = lane_chars[0][k];
          end
          if (dec.md5_long) begin
            for (int k = 0; k < 4; k++) begin
              str.chars[7+k] = lane_chars[1][k];
            end
            str.last_idx = LAST_MD5_LNG;
          end else begin
            str.last_idx = LAST_MD5;
          end
        end
        FORM_BF: begin
          str.chars[0] = CH_DOLLAR;
          str.chars[1] = CH_TWO;
          str.chars[2] = CH_LOW_A;
          str.chars[3] = CH_DOLLAR;
          str.chars[4] = CH_ZERO + {6'd0, tens};
          str.chars[5] = CH_ZERO + {3'd0, ones};
          str.chars[6] = CH_DOLLAR;
          for (int j = 0; j < NUM_LANES-1; j++) begin
            for (int k = 0; k < 4; k++) begin
              str.chars[7+4*j+k] = lane_chars[j][k];
            end
          end
          // trailing single byte gives two characters
          str.chars[STR_LEN-2] = lane_chars[NUM_LANES-1][0];
          str.chars[STR_LEN-1] = lane_chars[NUM_LANES-1][1];
          str.last_idx = LAST_BF;
        end
        default: begin
          str.last_idx = '0;
        end
      endcase
    end
  end

endmodule

### rtl/csse_serial.sv
// serializer: holds one assembled string and hands it out one character per result handshake
// depends on csse_pkg for the string type and csse_res_if for the result channel

module csse_serial (
  input  logic           clk,
  input  logic           rst,
  input  logic           load_valid,
  output logic           load_ready,
  input  csse_pkg::str_t str,
  csse_res_if.source     res
);
  import csse_pkg::*;

  logic                busy;
  char_t [STR_LEN-1:0] chars;
  idx_t                last_idx;
  logic                failed;
  idx_t                idx;
  logic                at_last;
  logic                load;

  assign at_last    = (idx == last_idx);
  assign load_ready = !busy || (res.ready && at_last);
  assign load       = load_valid && load_ready;

  // string buffer and character index
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && res.ready) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars    <= str.chars;
      last_idx <= str.last_idx;
      failed   <= str.failed;
    end
  end

  // result channel
  assign res.valid     = busy;
  assign res.text_char = chars[idx];
  assign res.last_char = at_last;
  assign res.failed    = failed;

endmodule

### rtl/crypt_salt_string_encoder_top.sv
// top level of the crypt salt string encoder: request register, checks, six lanes,
// merge stage and serializer; depends on csse_pkg, csse_if, csse_lane, csse_merge, csse_serial
//
//   channel  | dir | handshake     | carries
//   ---------+-----+---------------+------------------------------------------------
//   salt_req | in  | valid / ready | opcode, round_count, salt_lo, salt_hi, byte_count
//   text_res | out | valid / ready | text_char, last_char, failed
//   cfg      | in  | valid / ready | data (out_capacity), always ready
//
// a request is held in the request register until its string is loaded into the serializer,
// which gives one character per cycle while text_res is ready: 2 to 29 characters per
// request, 1 for a rejected one; the serializer output sets the sustained rate.
// the next request is taken while the current string is still being sent, and the
// serializer reloads in the cycle its last character is taken, so strings run gap-free.
// reset (rst, synchronous) empties both stages and sets out_capacity to 64.
// a stalled result holds its character; requests back up once the request register is full.

module crypt_salt_string_encoder_top (
  input  logic      clk,
  input  logic      rst,
  csse_req_if.sink  salt_req,
  csse_res_if.source text_res,
  csse_cfg_if.sink  cfg
);
  import csse_pkg::*;

  logic        capacity;
  logic [7:0]  cap;
  logic        held;
  logic [1:0]  opcode;
  logic [31:0] round_count;
  logic [63:0] salt_lo;
  logic [63:0] salt_hi;
  logic [4:0]  byte_count;
  logic        take;
  logic        load_ready;
  logic        req_acc;

  logic [15:0][7:0] sb;
  logic [4:0]       size;
  logic             cnt_zero;
  form_t            form;
  dec_t             dec;
  lane_mode_t       mode;
  tri_t [NUM_LANES-1:0]  lane_bytes;
  quad_t [NUM_LANES-1:0] lane_chars;
  str_t             str;

  // configuration register
  assign cfg.ready = 1'b1;
  assign capacity  = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (capacity) begin
      cap <= cfg.data;
    end
  end

  // request register
  assign take           = held && load_ready;
  assign salt_req.ready = !held || load_ready;
  assign req_acc        = salt_req.valid && salt_req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (req_acc) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      opcode      <= salt_req.opcode;
      round_count <= salt_req.round_count;
      salt_lo     <= salt_req.salt_lo;
      salt_hi     <= salt_req.salt_hi;
      byte_count  <= salt_req.byte_count;
    end
  end

  // request checks
  assign sb       = {salt_hi, salt_lo};
  assign size     = (byte_count > BYTES_MAX) ? BYTES_MAX : byte_count;
  assign cnt_zero = (round_count == '0);
  assign form     = form_t'(opcode);

  always_comb begin
    dec.form     = form;
    dec.md5_long = (size >= 5'd6) && (cap >= 8'd12);
    dec.cost     = cnt_zero ? BF_DEFAULT : round_count[4:0];
    unique case (form)
      FORM_TDES: dec.failed = (size < 5'd2) || (cap < 8'd3) ||
                              (!cnt_zero && round_count != TDES_ROUNDS);
      FORM_EDES: dec.failed = (size < 5'd3) || (cap < 8'd10) ||
                              (!cnt_zero && ((|round_count[31:24]) || !round_count[0]));
      FORM_MD5:  dec.failed = (size < 5'd3) || (cap < 8'd8) ||
                              (!cnt_zero && round_count != MD5_ROUNDS);
      FORM_BF:   dec.failed = (size < BYTES_MAX) || (cap < 8'd30) ||
                              (!cnt_zero && (round_count < 32'd4 || round_count > 32'd31));
      default:   dec.failed = 1'b1;
    endcase
  end

  // lane inputs: bcrypt byte triples by default; the two DES forms override the first two lanes
  assign mode = (form == FORM_BF) ? LANE_BE_BF : LANE_LE_STD;

  always_comb begin
    for (int j = 0; j < NUM_LANES-1; j++) begin
      for (int b = 0; b < 3; b++) begin
        lane_bytes[j][b] = sb[3*j+b];
      end
    end
    lane_bytes[NUM_LANES-1] = {8'd0, 8'd0, sb[15]};
    unique case (form)
      FORM_TDES: begin
        lane_bytes[0] = {8'd0, 8'd0, sb[0]};
        lane_bytes[1] = {8'd0, 8'd0, sb[1]};
      end
      FORM_EDES: begin
        if (cnt_zero) begin
          lane_bytes[0] = {EDES_DEFAULT[23:16], EDES_DEFAULT[15:8], EDES_DEFAULT[7:0]};
        end else begin
          lane_bytes[0] = {round_count[23:16], round_count[15:8], round_count[7:0]};
        end
        lane_bytes[1] = {sb[2], sb[1], sb[0]};
      end
      FORM_MD5: begin
        lane_bytes[0] = {sb[2], sb[1], sb[0]};
      end
      FORM_BF: begin
        lane_bytes[0] = {sb[2], sb[1], sb[0]};
      end
      default: begin
        lane_bytes[0] = {sb[2], sb[1], sb[0]};
      end
    endcase
  end

  // encoding lanes
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    csse_lane u_lane (
      .mode  (mode),
      .bytes (lane_bytes[g]),
      .chars (lane_chars[g])
    );
  end

  // string assembly
  csse_merge u_merge (
    .dec        (dec),
    .lane_chars (lane_chars),
    .str        (str)
  );

  // character output
  csse_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .load_valid (held),
    .load_ready (load_ready),
    .str        (str),
    .res        (text_res)
  );

endmodule

### rtl/csse_check.sv
// port-level checks of the crypt salt string encoder, bound to the top level
// depends on crypt_salt_string_encoder_top and its channel interfaces

module csse_check (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] text_char,
  input logic       last_char,
  input logic       failed
);

  // a rejected request is a single zero character that closes its string
  a_fail_single : assert property (@(posedge clk) disable iff (rst)
    res_valid && failed |-> last_char && text_char == 8'd0)
    else $error("failed result is not a single zero character");

  // a good string never carries a zero character
  a_char_nonzero : assert property (@(posedge clk) disable iff (rst)
    res_valid && !failed |-> text_char != 8'd0)
    else $error("zero character in a good string");

  // nothing is offered in the cycle after reset
  a_reset_empty : assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !res_valid)
    else $error("result offered right after reset");

  // a stalled result holds
  a_res_hold : assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(text_char) && $stable(last_char)
      && $stable(failed))
    else $error("stalled result changed");

endmodule

bind crypt_salt_string_encoder_top csse_check u_csse_check (
  .clk       (clk),
  .rst       (rst),
  .res_valid (text_res.valid),
  .res_ready (text_res.ready),
  .text_char (text_res.text_char),
  .last_char (text_res.last_char),
  .failed    (text_res.failed)
);
